### sv/mf3_pkg.sv
package mf3_pkg;

	localparam int PIX_W = 8;
	localparam int CFG_W = 16;
	localparam int WIDTH_W = 11;
	localparam int HEIGHT_W = 16;
	localparam int MIN_DIM = 3;
	localparam int WIN_TAPS = 9;
	localparam int WIN_HIST = 6;

	localparam logic REG_IMAGE_WIDTH = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RST = 11'd640;
	localparam logic [HEIGHT_W-1:0] IMAGE_HEIGHT_RST = 16'd480;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		pix_t pixel;
		logic frame_start;
	} in_beat_t;

	typedef struct packed {
		pix_t median;
		logic last_of_frame;
	} out_beat_t;

	typedef pix_t [WIN_TAPS-1:0] window_t;

endpackage

### sv/median_filter_3x3_top.sv
// Streaming 3x3 median filter for 8-bit grey images in raster order. One pixel
// beat is taken every clock when not stalled; a median beat is registered for
// the pixel that completes its window (row and column both two or more), and
// border pixels give no beat. The rate rests on the two line stores, each read
// and written once per pixel, with a forwarding path covering a read of the
// column still being written. last_of_frame marks the median of the last pixel
// of the frame. Width is clamped to 3..MAX_WIDTH and a height below 3 counts as
// 3; frames follow back to back, and frame_start restarts the position. The
// line stores are not cleared after reset: a frame's first two rows fill them.
module median_filter_3x3_top #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [mf3_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  mf3_pkg::in_beat_t         in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output mf3_pkg::out_beat_t        out_data
);
	import mf3_pkg::*;

	localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
	localparam int CMPW = (CW + 1 > WIDTH_W + 1) ? CW + 1 : WIDTH_W + 1;
	localparam int RW = HEIGHT_W + 1;

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [CW-1:0]       col_q;
	logic [HEIGHT_W-1:0] row_q;

	logic                s1_valid;
	pix_t                px_s1;
	logic [CW-1:0]       col_s1;
	logic                emit_s1;
	logic                last_s1;
	logic                byp_s1;
	pix_t                byp_up1_s1;
	pix_t                byp_up2_s1;
	pix_t                win_q [WIN_HIST];

	logic                accept;
	logic                adv_out;
	logic                adv_s1;
	logic [CW-1:0]       c_cur;
	logic [HEIGHT_W-1:0] r_cur;
	logic [CW:0]         c_plus1;
	logic [RW-1:0]       r_plus1;
	logic [CMPW-1:0]     w_ext;
	logic [CMPW-1:0]     w_eff;
	logic [HEIGHT_W-1:0] h_eff;
	logic                row_end;
	logic                frame_end;
	pix_t                ram_a;
	pix_t                ram_b;
	pix_t                up1;
	pix_t                up2;
	window_t             window;
	pix_t                median;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= IMAGE_WIDTH_RST;
			height_q <= IMAGE_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: width_q <= cfg_data[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv_out = !out_valid || !out_stall;
	assign adv_s1 = !emit_s1 || adv_out;
	assign in_stall = s1_valid && !adv_s1;
	assign accept = in_valid && !in_stall;

	always_comb begin
		c_cur = in_data.frame_start ? '0 : col_q;
		r_cur = in_data.frame_start ? '0 : row_q;
		c_plus1 = {1'b0, c_cur} + {{CW{1'b0}}, 1'b1};
		r_plus1 = {1'b0, r_cur} + {{HEIGHT_W{1'b0}}, 1'b1};
		w_ext = CMPW'(width_q);
		if (w_ext < CMPW'(MIN_DIM)) begin
			w_eff = CMPW'(MIN_DIM);
		end else if (w_ext > CMPW'(MAX_WIDTH)) begin
			w_eff = CMPW'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		h_eff = (height_q < HEIGHT_W'(MIN_DIM)) ? HEIGHT_W'(MIN_DIM) : height_q;
		row_end = CMPW'(c_plus1) >= w_eff;
		frame_end = row_end && (r_plus1 >= {1'b0, h_eff});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : r_plus1[HEIGHT_W-1:0];
			end else begin
				col_q <= c_plus1[CW-1:0];
				row_q <= r_cur;
			end
		end
	end

	assign up1 = byp_s1 ? byp_up1_s1 : ram_a;
	assign up2 = byp_s1 ? byp_up2_s1 : ram_b;

	mf3_line_ram #(.DEPTH(MAX_WIDTH), .AW(CW)) u_store_a (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (c_cur),
		.rd_data (ram_a),
		.wr_en   (s1_valid && adv_s1),
		.wr_addr (col_s1),
		.wr_data (px_s1)
	);

	mf3_line_ram #(.DEPTH(MAX_WIDTH), .AW(CW)) u_store_b (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (c_cur),
		.rd_data (ram_b),
		.wr_en   (s1_valid && adv_s1),
		.wr_addr (col_s1),
		.wr_data (up1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (accept) begin
			s1_valid <= 1'b1;
		end else if (adv_s1) begin
			s1_valid <= 1'b0;
		end
	end

	// A read of the column that stage one writes on the same edge takes the
	// new values directly.
	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1 <= in_data.pixel;
			col_s1 <= c_cur;
			emit_s1 <= (r_cur >= HEIGHT_W'(2)) && (c_cur >= CW'(2));
			last_s1 <= frame_end;
			byp_s1 <= s1_valid && (col_s1 == c_cur);
			byp_up1_s1 <= px_s1;
			byp_up2_s1 <= up1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_HIST; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_valid && adv_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= up2;
			win_q[4] <= up1;
			win_q[5] <= px_s1;
		end
	end

	always_comb begin
		for (int i = 0; i < WIN_HIST; i++) begin
			window[i] = win_q[i];
		end
		window[6] = up2;
		window[7] = up1;
		window[8] = px_s1;
	end

	mf3_median9 u_median (
		.win    (window),
		.median (median)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_out) begin
			out_valid <= s1_valid && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && s1_valid && emit_s1) begin
			out_data.median <= median;
			out_data.last_of_frame <= last_s1;
		end
	end

endmodule

### sv/mf3_line_ram.sv
module mf3_line_ram #(
	parameter int DEPTH = 1024,
	parameter int AW = 10
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output mf3_pkg::pix_t        rd_data,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  mf3_pkg::pix_t        wr_data
);
	import mf3_pkg::*;

	pix_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### sv/mf3_median9.sv
module mf3_median9 (
	input  mf3_pkg::window_t win,
	output mf3_pkg::pix_t    median
);
	import mf3_pkg::*;

	function automatic pix_t min2(input pix_t a, input pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t max2(input pix_t a, input pix_t b);
		return (a < b) ? b : a;
	endfunction

	function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	pix_t lo [3];
	pix_t mid [3];
	pix_t hi [3];

	// Sort each group of three, then the median of nine is the median of the
	// largest low, the middle middle and the smallest high.
	always_comb begin
		for (int g = 0; g < 3; g++) begin
			lo[g] = min2(min2(win[3*g], win[3*g+1]), win[3*g+2]);
			hi[g] = max2(max2(win[3*g], win[3*g+1]), win[3*g+2]);
			mid[g] = med3(win[3*g], win[3*g+1], win[3*g+2]);
		end
	end

	assign median = med3(max2(max2(lo[0], lo[1]), lo[2]),
			med3(mid[0], mid[1], mid[2]),
			min2(min2(hi[0], hi[1]), hi[2]));

endmodule

### verif/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mf3_pkg::*;

	localparam int LINE_LEN = 1024;
	localparam int RANDOM_PIXELS = 1050;

	function automatic int unsigned clamp_width(input logic [WIDTH_W-1:0] w);
		if (w < MIN_DIM) return MIN_DIM;
		if (w > LINE_LEN) return LINE_LEN;
		return w;
	endfunction

	class median_scoreboard;
		logic [WIDTH_W-1:0] width_reg;
		logic [HEIGHT_W-1:0] height_reg;
		pix_t row_above[LINE_LEN];
		pix_t row_above2[LINE_LEN];
		pix_t window_cols[WIN_HIST];
		int unsigned col;
		int unsigned row;
		out_beat_t expected_q[$];
		int errors;

		function new();
			width_reg = IMAGE_WIDTH_RST;
			height_reg = IMAGE_HEIGHT_RST;
			foreach (row_above[i]) begin
				row_above[i] = '0;
				row_above2[i] = '0;
			end
			foreach (window_cols[i]) window_cols[i] = '0;
			col = 0;
			row = 0;
			errors = 0;
		endfunction

		function void note_error(string what);
			errors++;
			if (errors <= 10) $display("%0t ns: %s", $time, what);
		endfunction

		function void write_reg(input logic idx, input logic [CFG_W-1:0] data);
			if (idx == REG_IMAGE_WIDTH) width_reg = data[WIDTH_W-1:0];
			else height_reg = data[HEIGHT_W-1:0];
		endfunction

		function void note_pixel(input in_beat_t beat);
			pix_t taps[WIN_TAPS];
			pix_t up1;
			pix_t up2;
			pix_t t;
			int unsigned w;
			int unsigned h;
			bit row_end;
			bit frame_end;
			int j;
			out_beat_t beat_out;
			w = clamp_width(width_reg);
			h = (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
			if (beat.frame_start) begin
				col = 0;
				row = 0;
			end
			up1 = row_above[col];
			up2 = row_above2[col];
			row_end = (col + 1 >= w);
			frame_end = row_end && (row + 1 >= h);
			if (row >= 2 && col >= 2) begin
				taps = '{window_cols[0], window_cols[1], window_cols[2], window_cols[3],
					window_cols[4], window_cols[5], up2, up1, beat.pixel};
				for (int i = 1; i < WIN_TAPS; i++) begin
					t = taps[i];
					j = i;
					while (j > 0 && taps[j-1] > t) begin
						taps[j] = taps[j-1];
						j--;
					end
					taps[j] = t;
				end
				beat_out.median = taps[4];
				beat_out.last_of_frame = frame_end;
				expected_q = {expected_q, beat_out};
			end
			row_above2[col] = up1;
			row_above[col] = beat.pixel;
			window_cols[0] = window_cols[3];
			window_cols[1] = window_cols[4];
			window_cols[2] = window_cols[5];
			window_cols[3] = up2;
			window_cols[4] = up1;
			window_cols[5] = beat.pixel;
			if (row_end) begin
				col = 0;
				row = frame_end ? 0 : (row + 1) % 65536;
			end else begin
				col = col + 1;
			end
		endfunction

		function void check_median(input out_beat_t got);
			out_beat_t want;
			if (expected_q.size() == 0) begin
				note_error($sformatf("median beat %0d/%0b with none expected",
					got.median, got.last_of_frame));
				return;
			end
			want = expected_q.pop_front();
			if (got.median !== want.median || got.last_of_frame !== want.last_of_frame)
				note_error($sformatf("median %0d last %0b, expected median %0d last %0b",
					got.median, got.last_of_frame, want.median, want.last_of_frame));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_beat_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_beat_t out_data;

	median_scoreboard sb = new();
	bit calm = 1'b0;
	int stall_left = 0;

	median_filter_3x3_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_pixel(in_data);
			if (out_valid && !out_stall) sb.check_median(out_data);
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (!calm && $urandom_range(0, 99) < 25) begin
			out_stall <= 1'b1;
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) :
				$urandom_range(0, 2);
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic program_reg(input logic idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic send_pixel(input pix_t value, input logic fs);
		int gap;
		int pick;
		pick = $urandom_range(0, 99);
		if (calm || pick < 55) gap = 0;
		else if (pick < 90) gap = $urandom_range(1, 3);
		else gap = $urandom_range(8, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= in_beat_t'{pixel: value, frame_start: fs};
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_pixels(input int count, input bit fs_first, input int style);
		pix_t value;
		pix_t base;
		logic fs;
		base = 8'($urandom);
		for (int k = 0; k < count; k++) begin
			case (style)
				0: value = 8'($urandom);
				1: value = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
					(($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00);
				default: value = base + 8'($urandom_range(0, 3));
			endcase
			fs = (k == 0 && fs_first) || (sb.col == 0 && sb.row == 0 &&
				$urandom_range(0, 1) == 1) || ($urandom_range(0, 59) == 0);
			send_pixel(value, fs);
		end
	endtask

	initial begin
		pix_t first_frame[9];
		pix_t second_frame[9];
		int sent;
		int count;
		int lim;
		int unsigned w_now;
		int unsigned h_now;
		bit fs_first;
		bit do_w;
		bit do_h;
		logic [CFG_W-1:0] w_data;
		logic [CFG_W-1:0] h_data;

		first_frame = '{8'd0, 8'd255, 8'd128, 8'd255, 8'd0, 8'd127,
			8'd85, 8'd170, 8'd255};
		second_frame = '{8'd255, 8'd254, 8'd1, 8'd200, 8'd200, 8'd3,
			8'd200, 8'd7, 8'd0};

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Geometry as left by reset: two full rows of 640 and a few pixels more.
		send_pixels(2 * 640 + 10, 1'b1, 0);
		wait_idle();

		// Smallest frame: both registers below range, two frames back to back.
		program_reg(REG_IMAGE_WIDTH, 16'h0000);
		program_reg(REG_IMAGE_HEIGHT, 16'h0001);
		foreach (first_frame[i]) send_pixel(first_frame[i], i == 0);
		foreach (second_frame[i]) send_pixel(second_frame[i], 1'b0);
		send_pixel(8'h0F, 1'b0);
		send_pixel(8'hF0, 1'b0);
		wait_idle();

		// Widest frame: the width saturates and the height is raised to three.
		program_reg(REG_IMAGE_WIDTH, 16'h07FF);
		program_reg(REG_IMAGE_HEIGHT, 16'h0000);
		send_pixels(3 * LINE_LEN, 1'b1, 0);

		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			wait_idle();
			calm = ($urandom_range(0, 4) == 0);
			fs_first = ($urandom_range(0, 3) == 0);
			do_w = 1'b0;
			do_h = 1'b0;
			w_data = '0;
			h_data = '0;
			case ($urandom_range(0, 9))
				0: begin
					do_w = 1'b1;
					w_data = 16'($urandom_range(0, 2)) | (16'($urandom_range(0, 31)) << 11);
				end
				1: begin
					do_w = 1'b1;
					w_data = 16'($urandom_range(13, 48));
				end
				2: begin
					do_h = 1'b1;
					h_data = ($urandom_range(0, 1) == 1) ? 16'hFFFF :
						16'($urandom_range(0, 2));
				end
				3: ;
				default: begin
					do_w = 1'b1;
					do_h = 1'b1;
					w_data = 16'($urandom_range(3, 12));
					h_data = 16'($urandom_range(3, 6));
				end
			endcase
			if (do_w) begin
				// A wider row is only safe once the line stores are refilled from row zero.
				if (clamp_width(w_data[WIDTH_W-1:0]) > clamp_width(sb.width_reg) && sb.row != 0)
					fs_first = 1'b1;
				program_reg(REG_IMAGE_WIDTH, w_data);
			end
			if (do_h) program_reg(REG_IMAGE_HEIGHT, h_data);
			w_now = clamp_width(sb.width_reg);
			h_now = (sb.height_reg < MIN_DIM) ? MIN_DIM : sb.height_reg;
			if (h_now > 8) h_now = 8;
			lim = 3 * w_now * h_now;
			if (lim > 200) lim = 200;
			count = $urandom_range(4, lim);
			send_pixels(count, fs_first, $urandom_range(0, 2));
			sent += count;
		end

		calm = 1'b0;
		wait_idle();
		repeat (8) @(negedge clk);
		if (sb.expected_q.size() != 0)
			sb.note_error($sformatf("%0d median beats never arrived", sb.expected_q.size()));
		if (sb.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

### median_filter_3x3_top.f
sv/mf3_pkg.sv
sv/mf3_line_ram.sv
sv/mf3_median9.sv
sv/median_filter_3x3_top.sv
verif/tb_top.sv
